/* hw/rtl/bfgt_pkg.sv */
// Shared constants, operation codes and control types of the breadth-first traversal block.
package bfgt_pkg;

   localparam int MAX_NODES = 64;
   localparam int ROW_W     = MAX_NODES;
   localparam int ADDR_W    = $clog2(MAX_NODES);
   localparam int PTR_W     = ADDR_W + 1;
   localparam int NODE_W    = 6;
   localparam int CNT_W     = 7;

   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_ADD_EDGE = 2'd0,
      OP_TRAVERSE = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

   typedef struct packed {
      logic load;
      logic step;
   } pick_ctrl_type;

endpackage

/* hw/rtl/bfgt_ram.sv */
// Generic simple dual-port RAM with registered read.
module bfgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/bfgt_pick.sv */
// Candidate neighbour register with lowest-index selection, one node per step.
module bfgt_pick import bfgt_pkg::*; (
   input  logic              clock,
   input  pick_ctrl_type     ctrl,
   input  logic [ROW_W-1:0]  load_mask,
   output logic              any,
   output logic [ADDR_W-1:0] idx
);

   logic [ROW_W-1:0] cand_ff;
   logic [ROW_W-1:0] cand_in;
   logic [ROW_W-1:0] lowbit;

   assign lowbit = cand_ff & (~cand_ff + ROW_W'(1));
   assign any    = |cand_ff;

   always_comb begin
      idx = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (lowbit[i]) begin
            idx = idx | ADDR_W'(i);
         end
      end
   end

   always_comb begin
      cand_in = cand_ff;
      if (ctrl.load) begin
         cand_in = load_mask;
      end else if (ctrl.step) begin
         cand_in = cand_ff & ~lowbit;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

endmodule

/* hw/rtl/breadth_first_graph_traversal.sv */
// Breadth-first traversal over an undirected adjacency matrix held in RAM.
// The block takes one item at a time. Clearing all edges drops the row-valid flags; adding an
// edge does a read-modify-write of both rows through the single adjacency read port. In a
// traversal each dequeue costs a queue read and an adjacency row read, and each newly
// found neighbour one queue write. Results leave through an output register, so the next
// node is worked on while the previous result waits; a stalled result holds the traversal.
// node_count limits which neighbours are followed; the start node is always emitted first.
module breadth_first_graph_traversal import bfgt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [5:0] node_a, [11:6] node_b, [15:12] zero
   input  logic [1:0]        req_tuser,   // [1:0] op
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [5:0] visited_node, [7:6] zero
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic [CNT_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_RD_A,
      S_EDGE_WR_A,
      S_EDGE_RD_B,
      S_EDGE_WR_B,
      S_Q_RD,
      S_ROW_RD,
      S_ROW_DATA,
      S_ENQ
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [ROW_W-1:0]   row_valid_ff, row_valid_in;
   logic [CNT_W-1:0]   node_count_ff, node_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [ROW_W-1:0]   visited_ff, visited_in;
   logic [NODE_W-1:0]  a_ff, a_in;
   logic [NODE_W-1:0]  b_ff, b_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic               rdv_ff, rdv_in;

   logic [NODE_W-1:0]  req_node_a;
   logic [NODE_W-1:0]  req_node_b;
   op_type             req_op;
   logic               a_ok;
   logic               b_ok;

   logic               adj_we;
   logic [ADDR_W-1:0]  adj_waddr;
   logic [ROW_W-1:0]   adj_wdata;
   logic               adj_re;
   logic [ADDR_W-1:0]  adj_raddr;
   logic [ROW_W-1:0]   adj_rdata;
   logic [ROW_W-1:0]   row_base;

   logic               q_we;
   logic [ADDR_W-1:0]  q_waddr;
   logic [NODE_W-1:0]  q_wdata;
   logic               q_re;
   logic [ADDR_W-1:0]  q_raddr;
   logic [NODE_W-1:0]  q_rdata;

   pick_ctrl_type      pick_ctrl;
   logic [ROW_W-1:0]   pick_mask;
   logic               pick_any;
   logic [ADDR_W-1:0]  pick_idx;
   logic [ROW_W-1:0]   limit_mask;
   logic               out_free;
   logic               q_empty;

   assign req_node_a = req_tdata[5:0];
   assign req_node_b = req_tdata[11:6];
   assign req_op     = op_type'(req_tuser);
   assign a_ok       = {1'b0, req_node_a} < CNT_W'(MAX_NODES);
   assign b_ok       = {1'b0, req_node_b} < CNT_W'(MAX_NODES);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a row never written since the last clear reads as empty
   assign row_base = rdv_ff ? adj_rdata : '0;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_empty  = (head_ff == tail_ff);

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         limit_mask[i] = CNT_W'(i) < node_count_ff;
      end
   end

   assign pick_mask = row_base & ~visited_ff & limit_mask;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      row_valid_in  = row_valid_ff;
      node_count_in = node_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_node_in   = rsp_node_ff;
      rsp_last_in   = rsp_last_ff;
      visited_in    = visited_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;

      adj_we    = 1'b0;
      adj_waddr = a_ff[ADDR_W-1:0];
      adj_wdata = row_base | (ROW_W'(1) << b_ff[ADDR_W-1:0]);
      adj_re    = 1'b0;
      adj_raddr = a_ff[ADDR_W-1:0];
      q_we      = 1'b0;
      q_waddr   = tail_ff[ADDR_W-1:0];
      q_wdata   = NODE_W'(pick_idx);
      q_re      = 1'b0;
      q_raddr   = head_ff[ADDR_W-1:0];
      pick_ctrl = '0;

      if (csr_we) begin
         node_count_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_ADD_EDGE: begin
                     if (a_ok && b_ok) begin
                        a_in     = req_node_a;
                        b_in     = req_node_b;
                        state_in = S_EDGE_RD_A;
                     end
                  end
                  OP_TRAVERSE: begin
                     if (a_ok) begin
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        q_wdata    = req_node_a;
                        visited_in = ROW_W'(1) << req_node_a[ADDR_W-1:0];
                        head_in    = '0;
                        tail_in    = PTR_W'(1);
                        state_in   = S_Q_RD;
                     end
                  end
                  OP_CLEAR: begin
                     row_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EDGE_RD_A: begin
            adj_re   = 1'b1;
            state_in = S_EDGE_WR_A;
         end
         S_EDGE_WR_A: begin
            adj_we                            = 1'b1;
            row_valid_in[a_ff[ADDR_W-1:0]]    = 1'b1;
            state_in                          = S_EDGE_RD_B;
         end
         S_EDGE_RD_B: begin
            adj_re    = 1'b1;
            adj_raddr = b_ff[ADDR_W-1:0];
            state_in  = S_EDGE_WR_B;
         end
         S_EDGE_WR_B: begin
            adj_we                            = 1'b1;
            adj_waddr                         = b_ff[ADDR_W-1:0];
            adj_wdata                         = row_base | (ROW_W'(1) << a_ff[ADDR_W-1:0]);
            row_valid_in[b_ff[ADDR_W-1:0]]    = 1'b1;
            state_in                          = S_IDLE;
         end
         S_Q_RD: begin
            q_re     = 1'b1;
            head_in  = head_ff + PTR_W'(1);
            state_in = S_ROW_RD;
         end
         S_ROW_RD: begin
            cur_in    = q_rdata;
            adj_re    = 1'b1;
            adj_raddr = q_rdata[ADDR_W-1:0];
            state_in  = S_ROW_DATA;
         end
         S_ROW_DATA: begin
            pick_ctrl.load = 1'b1;
            state_in       = S_ENQ;
         end
         S_ENQ: begin
            if (pick_any) begin
               // enqueue the lowest unvisited neighbour and mark it
               q_we           = 1'b1;
               visited_in     = visited_ff | (ROW_W'(1) << pick_idx);
               tail_in        = tail_ff + PTR_W'(1);
               pick_ctrl.step = 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = cur_ff;
               rsp_last_in  = q_empty;
               state_in     = q_empty ? S_IDLE : S_Q_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rdv_in = row_valid_ff[adj_raddr];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         row_valid_ff  <= '0;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         row_valid_ff  <= row_valid_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      visited_ff <= visited_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      cur_ff     <= cur_in;
      rdv_ff     <= rdv_in;
   end

   bfgt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   bfgt_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   bfgt_pick u_pick (
      .clock     (clock),
      .ctrl      (pick_ctrl),
      .load_mask (pick_mask),
      .any       (pick_any),
      .idx       (pick_idx)
   );

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= PTR_W'(MAX_NODES))
      else $error("queue tail beyond capacity");

   a_enq_unvisited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENQ && pick_any) |-> !visited_ff[pick_idx])
      else $error("enqueued a node already visited");

   a_marks_match_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_RD || state_ff == S_ROW_RD || state_ff == S_ROW_DATA ||
       state_ff == S_ENQ) |-> ($countones(visited_ff) == int'(tail_ff)))
      else $error("visited marks out of step with queue tail");

endmodule

/* test/tb_breadth_first_graph_traversal.sv */
// Testbench for the breadth-first traversal block: a directed table, then random graphs.
`timescale 1ns / 1ps

module tb_breadth_first_graph_traversal;
   import bfgt_pkg::*;

   localparam int         HALF_PERIOD    = 5;
   localparam int         RESET_CYCLES   = 10;
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         CYCLE_LIMIT    = 1_000_000;
   localparam int         RANDOM_ITEMS   = 180;
   localparam int         REPORT_MAX     = 10;
   localparam int         IDLE_LOW_PCT   = 9;
   localparam int         IDLE_HIGH_PCT  = 45;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_SOLO,
      ROW_COUNT
   } row_kind_type;

   typedef enum int {
      PACE_SEND_FAST,
      PACE_RECV_FAST,
      PACE_FULL
   } pace_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        op;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [CNT_W-1:0]  count;
      logic [NODE_W-1:0] solo_node;
   } plan_row_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              last;
   } visit_type;

   localparam int PLAN_ROWS = 25;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_SOLO,  OP_TRAVERSE, 6'd0,  6'd0,  7'd0,   6'd0},
      '{ROW_SOLO,  OP_TRAVERSE, 6'd63, 6'd0,  7'd0,   6'd63},
      '{ROW_ITEM,  OP_UNUSED,   6'd63, 6'd63, 7'd0,   6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd0,  6'd63, 7'd0,   6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd5,  6'd5,  7'd0,   6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd63, 6'd1,  7'd0,   6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd0,  6'd2,  7'd0,   6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd2,  6'd62, 7'd0,   6'd0},
      '{ROW_ITEM,  OP_TRAVERSE, 6'd0,  6'd0,  7'd0,   6'd0},
      '{ROW_SOLO,  OP_TRAVERSE, 6'd5,  6'd0,  7'd0,   6'd5},
      '{ROW_ITEM,  OP_TRAVERSE, 6'd62, 6'd0,  7'd0,   6'd0},
      '{ROW_COUNT, OP_ADD_EDGE, 6'd0,  6'd0,  7'd0,   6'd0},
      '{ROW_SOLO,  OP_TRAVERSE, 6'd0,  6'd0,  7'd0,   6'd0},
      '{ROW_COUNT, OP_ADD_EDGE, 6'd0,  6'd0,  7'd1,   6'd0},
      '{ROW_ITEM,  OP_TRAVERSE, 6'd63, 6'd0,  7'd0,   6'd0},
      '{ROW_COUNT, OP_ADD_EDGE, 6'd0,  6'd0,  7'd127, 6'd0},
      '{ROW_ITEM,  OP_TRAVERSE, 6'd1,  6'd0,  7'd0,   6'd0},
      '{ROW_COUNT, OP_ADD_EDGE, 6'd0,  6'd0,  7'd63,  6'd0},
      '{ROW_ITEM,  OP_TRAVERSE, 6'd0,  6'd0,  7'd0,   6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd63, 6'd63, 7'd0,   6'd0},
      '{ROW_ITEM,  OP_CLEAR,    6'd0,  6'd0,  7'd0,   6'd0},
      '{ROW_SOLO,  OP_TRAVERSE, 6'd2,  6'd0,  7'd0,   6'd2},
      '{ROW_COUNT, OP_ADD_EDGE, 6'd0,  6'd0,  7'd64,  6'd0},
      '{ROW_ITEM,  OP_ADD_EDGE, 6'd10, 6'd11, 7'd0,   6'd0},
      '{ROW_ITEM,  OP_TRAVERSE, 6'd11, 6'd0,  7'd0,   6'd0}
   };

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata  = '0;   // [5:0] node_a, [11:6] node_b, [15:12] zero
   logic [1:0]        req_tuser  = '0;   // [1:0] op
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;         // [5:0] visited_node, [7:6] zero
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic [CNT_W-1:0]  csr_wdata  = '0;

   // Mirror of the block's graph and count register
   logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
   logic [CNT_W-1:0]     count_reg = NODE_COUNT_RESET;
   visit_type            visit_q [$];

   pace_type pace      = PACE_SEND_FAST;
   int       err_count = 0;
   int       cycle_cnt = 0;

   breadth_first_graph_traversal u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Breadth-first walk over the mirrored matrix; queues the visit order
   function automatic void predict_walk(input logic [NODE_W-1:0] start);
      logic [MAX_NODES-1:0] seen;
      logic [NODE_W-1:0]    fifo [MAX_NODES];
      logic [NODE_W-1:0]    cur;
      int                   head;
      int                   tail;
      int                   lim;
      lim  = (count_reg > MAX_NODES) ? MAX_NODES : int'(count_reg);
      seen = '0;
      seen[start] = 1'b1;
      fifo[0] = start;
      head = 0;
      tail = 1;
      while (head < tail) begin
         cur = fifo[head];
         head++;
         for (int i = 0; i < lim; i++) begin
            if (adj_rows[cur][i] && !seen[i]) begin
               seen[i]    = 1'b1;
               fifo[tail] = NODE_W'(i);
               tail++;
            end
         end
         visit_q.push_back('{node: cur, last: (head == tail)});
      end
   endfunction

   function automatic void predict_item(input logic [1:0] op, input logic [NODE_W-1:0] a,
                                        input logic [NODE_W-1:0] b);
      case (op)
         OP_ADD_EDGE: begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
         end
         OP_TRAVERSE: predict_walk(a);
         OP_CLEAR: begin
            for (int r = 0; r < MAX_NODES; r++) adj_rows[r] = '0;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b, input logic solo,
                            input logic [NODE_W-1:0] solo_node);
      int gap_pct;
      gap_pct = (pace == PACE_SEND_FAST) ? IDLE_LOW_PCT :
                (pace == PACE_RECV_FAST) ? IDLE_HIGH_PCT : 0;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // valid stays high: the next item may follow on the very next cycle
      if (solo) visit_q.push_back('{node: solo_node, last: 1'b1});
      else predict_item(op, a, b);
   endtask

   // Drop valid, let every expected transfer arrive, then allow for an edge still in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (visit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      count_reg = value;
      csr_we    <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_side
      visit_type want;
      int        stall_pct;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (visit_q.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_MAX)
               $display("unexpected transfer: node %0d last %0b", rsp_tdata[NODE_W-1:0],
                        rsp_tlast);
         end else begin
            want = visit_q.pop_front();
            if (rsp_tdata[NODE_W-1:0] !== want.node || rsp_tlast !== want.last) begin
               err_count++;
               if (err_count <= REPORT_MAX)
                  $display("mismatch: expected node %0d last %0b, got node %0d last %0b",
                           want.node, want.last, rsp_tdata[NODE_W-1:0], rsp_tlast);
            end
         end
      end
      stall_pct = (pace == PACE_SEND_FAST) ? IDLE_HIGH_PCT :
                  (pace == PACE_RECV_FAST) ? IDLE_LOW_PCT : 0;
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin : stimulus
      int                sent;
      int                phase;
      int                lo;
      int                span;
      int                n_edges;
      int                n_walks;
      int                k;
      int                tmp;
      int                perm [MAX_NODES];
      logic [CNT_W-1:0]  cnt;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;

      predict_item(OP_CLEAR, '0, '0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_COUNT) write_count(PLAN[r].count);
         else send_item(PLAN[r].op, PLAN[r].node_a, PLAN[r].node_b,
                        PLAN[r].kind == ROW_SOLO, PLAN[r].solo_node);
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pace = (sent < RANDOM_ITEMS / 3)     ? PACE_SEND_FAST :
                (sent < 2 * RANDOM_ITEMS / 3) ? PACE_RECV_FAST : PACE_FULL;
         if (phase > 0 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0:       cnt = 7'd0;
               1:       cnt = 7'd1;
               2:       cnt = 7'd127;
               3:       cnt = CNT_W'($urandom_range(0, 127));
               default: cnt = 7'd64;
            endcase
            write_count(cnt);
         end
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom), 1'b0, '0);
            sent++;
         end

         // The first phase links all nodes into one chain for the longest walk
         if (phase == 0) begin
            span = MAX_NODES;
            lo   = 0;
         end else begin
            span = ($urandom_range(0, 9) == 0) ? MAX_NODES : $urandom_range(2, 16);
            lo   = $urandom_range(0, MAX_NODES - span);
         end
         for (int j = 0; j < span; j++) perm[j] = lo + j;
         for (int j = span - 1; j > 0; j--) begin
            k       = $urandom_range(0, j);
            tmp     = perm[j];
            perm[j] = perm[k];
            perm[k] = tmp;
         end

         n_edges = (phase == 0 || $urandom_range(0, 1) == 0) ? span - 1
                                                            : $urandom_range(1, 2 * span);
         // Stop adding edges once the item budget is spent
         for (int j = 0; j < n_edges && sent < RANDOM_ITEMS; j++) begin
            if ($urandom_range(0, 15) == 0)
               send_item(OP_UNUSED, NODE_W'($urandom), NODE_W'($urandom), 1'b0, '0);
            if (n_edges == span - 1) begin
               a = NODE_W'(perm[j]);
               b = NODE_W'(perm[j + 1]);
            end else if ($urandom_range(0, 7) == 0) begin
               a = NODE_W'($urandom);
               b = NODE_W'($urandom);
            end else begin
               a = NODE_W'(perm[$urandom_range(0, span - 1)]);
               b = NODE_W'(perm[$urandom_range(0, span - 1)]);
            end
            send_item(OP_ADD_EDGE, a, b, 1'b0, '0);
            sent++;
         end

         n_walks = $urandom_range(1, 3);
         for (int j = 0; j < n_walks; j++) begin
            a = ($urandom_range(0, 4) == 0) ? NODE_W'($urandom)
                                            : NODE_W'(perm[$urandom_range(0, span - 1)]);
            send_item(OP_TRAVERSE, a, NODE_W'($urandom), 1'b0, '0);
            sent++;
         end
         phase++;
      end

      wait_idle();
      if (err_count == 0 && visit_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/bfgt_pkg.sv
hw/rtl/bfgt_ram.sv
hw/rtl/bfgt_pick.sv
hw/rtl/breadth_first_graph_traversal.sv
test/tb_breadth_first_graph_traversal.sv
